// ----- hdl/fsqr_pkg.sv -----
// ----------------------------------------------------------------------------
// fsqr_pkg
// Shared widths and types for the fixed-point square root pipeline.
// ----------------------------------------------------------------------------
package fsqr_pkg;

	localparam int FRACTION_BITS = 64;              // 1 .. 64
	localparam int RADICAND_W    = 64;
	localparam int INT_W         = 32;
	localparam int FRAC_W        = 64;              // field width, fixed
	localparam int ROOT_W        = INT_W + FRACTION_BITS;
	localparam int REM_W         = ROOT_W + 2;
	localparam int NUM_CELLS     = ROOT_W;          // one root bit per cell
	localparam int OUT_W         = INT_W + FRAC_W;  // 96, already whole bytes

	// partial result carried from cell to cell
	typedef struct packed {
		logic [REM_W-1:0]      rem;
		logic [ROOT_W-1:0]     root;
		logic [RADICAND_W-1:0] rad;   // radicand pairs not yet consumed, msb first
	} stage_t;

endpackage

// ----- hdl/fsqr_cell.sv -----
// ----------------------------------------------------------------------------
// fsqr_cell
// One restoring step: brings down two radicand bits, tries root*4+1,
// keeps the difference if it fits and shifts the new root bit in.
// ----------------------------------------------------------------------------
module fsqr_cell (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             adv,
	input  logic             in_valid,
	input  fsqr_pkg::stage_t in_data,
	output logic             out_valid,
	output fsqr_pkg::stage_t out_data
);

	logic [fsqr_pkg::REM_W-1:0] rem_sh;
	logic [fsqr_pkg::REM_W-1:0] trial;
	logic                       fits;
	fsqr_pkg::stage_t           nxt;
	logic                       valid_q;
	fsqr_pkg::stage_t           data_q;

	always_comb begin
		rem_sh   = {in_data.rem[fsqr_pkg::REM_W-3:0],
		            in_data.rad[fsqr_pkg::RADICAND_W-1 -: 2]};
		trial    = {in_data.root, 2'b01};
		fits     = (rem_sh >= trial);
		nxt.rem  = fits ? (rem_sh - trial) : rem_sh;
		nxt.root = {in_data.root[fsqr_pkg::ROOT_W-2:0], fits};
		nxt.rad  = {in_data.rad[fsqr_pkg::RADICAND_W-3:0], 2'b00};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (adv) begin
			valid_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && in_valid) begin
			data_q <= nxt;
		end
	end

	assign out_valid = valid_q;
	assign out_data  = data_q;

endmodule

// ----- hdl/fsqr_skid.sv -----
// ----------------------------------------------------------------------------
// fsqr_skid
// Output register plus one skid entry, so the cell chain keeps moving
// while a finished beat waits on the master side.
// ----------------------------------------------------------------------------
module fsqr_skid (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	input  logic [fsqr_pkg::OUT_W-1:0] in_data,
	output logic                       in_ready,
	output logic                       out_valid,
	input  logic                       out_ready,
	output logic [fsqr_pkg::OUT_W-1:0] out_data
);

	logic                       out_valid_q;
	logic [fsqr_pkg::OUT_W-1:0] out_data_q;
	logic                       skid_valid_q;
	logic [fsqr_pkg::OUT_W-1:0] skid_data_q;
	logic                       pop;
	logic                       push;

	assign in_ready = !skid_valid_q;
	assign pop      = out_valid_q && out_ready;
	assign push     = in_valid && !skid_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (skid_valid_q) begin
			if (pop) begin
				skid_valid_q <= 1'b0;
			end
		end else if (push) begin
			if (out_valid_q && !pop) begin
				skid_valid_q <= 1'b1;
			end else begin
				out_valid_q <= 1'b1;
			end
		end else if (pop) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (skid_valid_q) begin
			if (pop) begin
				out_data_q <= skid_data_q;
			end
		end else if (push) begin
			if (out_valid_q && !pop) begin
				skid_data_q <= in_data;
			end else begin
				out_data_q <= in_data;
			end
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

endmodule

// ----- hdl/fixed_point_square_root.sv -----
// ----------------------------------------------------------------------------
// fixed_point_square_root
// Returns floor(sqrt(n) * 2^FRACTION_BITS) for an unsigned 64-bit radicand.
// ----------------------------------------------------------------------------
// Accepts one radicand per clock while s_tready is high and returns one beat
// per radicand, in order. The root is built by a chain of 96 identical cells
// (32 integer plus FRACTION_BITS fraction bits), each producing one root bit
// per cycle while the chain advances; an accepted beat passes through the
// cell registers and then the output register. A master-side stall is
// absorbed by one skid entry; the chain then holds until it drains.
// The fraction is truncated and right-aligned; bits above FRACTION_BITS are 0.
module fixed_point_square_root (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_tvalid,
	output logic                            s_tready,
	input  logic [fsqr_pkg::RADICAND_W-1:0] s_tdata,  // [63:0] radicand
	output logic                            m_tvalid,
	input  logic                            m_tready,
	output logic [fsqr_pkg::OUT_W-1:0]      m_tdata   // [31:0] root_integer,
	                                                  // [95:32] root_fraction
);

	logic                                     adv;
	logic             [fsqr_pkg::NUM_CELLS:0] valid_chain;
	fsqr_pkg::stage_t [fsqr_pkg::NUM_CELLS:0] data_chain;
	logic             [fsqr_pkg::ROOT_W-1:0]  root_final;
	logic             [fsqr_pkg::OUT_W-1:0]   result;

	assign s_tready = adv;

	assign valid_chain[0]    = s_tvalid;
	assign data_chain[0].rem  = '0;
	assign data_chain[0].root = '0;
	assign data_chain[0].rad  = s_tdata;

	for (genvar g = 0; g < fsqr_pkg::NUM_CELLS; g++) begin : g_cell
		fsqr_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.adv       (adv),
			.in_valid  (valid_chain[g]),
			.in_data   (data_chain[g]),
			.out_valid (valid_chain[g+1]),
			.out_data  (data_chain[g+1])
		);
	end

	assign root_final = data_chain[fsqr_pkg::NUM_CELLS].root;
	assign result = {
		fsqr_pkg::FRAC_W'(root_final[fsqr_pkg::FRACTION_BITS-1:0]),
		root_final[fsqr_pkg::ROOT_W-1:fsqr_pkg::FRACTION_BITS]
	};

	fsqr_skid u_skid (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (valid_chain[fsqr_pkg::NUM_CELLS]),
		.in_data   (result),
		.in_ready  (adv),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_data  (m_tdata)
	);

endmodule
